/* src/rsmp_pkg.sv */
package rsmp_pkg;

	localparam int WORD_W = 32;
	localparam int SLOT_W = 4;
	localparam int CFG_W  = 5;
	localparam int STEP_W = 5;

	localparam logic [WORD_W-1:0] SEEN_MAX = '1;
	localparam logic [CFG_W-1:0]  SIZE_RESET = CFG_W'(16);

	typedef struct packed {
		logic [WORD_W-1:0] item_value;
		logic [WORD_W-1:0] random_word;
		logic              last_item;
	} in_t;

	typedef struct packed {
		logic [SLOT_W-1:0] sample_slot;
		logic [WORD_W-1:0] sample_value;
		logic              last_sample;
	} out_t;

endpackage

/* src/reservoir_sampler.sv */
// channel  | handshake            | payload
// in       | in_valid / in_stall  | in_data   (rsmp_pkg::in_t)
// out      | out_valid / out_stall| out_data  (rsmp_pkg::out_t)
// cfg      | cfg_we               | cfg_data  (reservoir_size)
//
// An item that still fills the reservoir goes from accept straight to the update; a later one
// passes through the 32 steps of the serial remainder unit between accept and update.
// A request marked last then emits min(count, size) samples, each with a memory read,
// then an output hold that lasts while out_stall is high.
// arst_n clears control state and the item count; reservoir contents are not reset.
// in_stall is high from accept until the item and any emitted samples are done.
module reservoir_sampler #(
	parameter int RESERVOIR_DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  rsmp_pkg::in_t                 in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output rsmp_pkg::out_t                out_data,
	input  logic                          cfg_we,
	input  logic [rsmp_pkg::CFG_W-1:0]    cfg_data
);

	localparam int AW   = (RESERVOIR_DEPTH > 1) ? $clog2(RESERVOIR_DEPTH) : 1;
	localparam int SZ_W = $clog2(RESERVOIR_DEPTH + 1);
	localparam int W    = rsmp_pkg::WORD_W;
	localparam logic [W-1:0] DEPTH_W = W'(RESERVOIR_DEPTH);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_APPLY,
		ST_EMIT_RD,
		ST_EMIT_OUT
	} state_t;

	state_t state_q;

	logic [rsmp_pkg::CFG_W-1:0]  size_cfg_q;
	logic [W-1:0]                seen_q;
	logic [W-1:0]                item_q;
	logic                        last_q;
	logic [W-1:0]                size_q;
	logic [W-1:0]                rem_q;
	logic [W-1:0]                dvd_q;
	logic [W:0]                  div_q;
	logic [rsmp_pkg::STEP_W-1:0] step_q;
	logic [SZ_W-1:0]             k_q;
	logic [SZ_W-1:0]             count_q;
	logic [W-1:0]                rd_q;

	logic [W-1:0] mem [RESERVOIR_DEPTH];

	logic [W-1:0] size_eff;
	logic [W-1:0] cfg_w;
	logic [W:0]   shifted;
	logic [W-1:0] rem_next;
	logic [W-1:0] seen_next;
	logic [W-1:0] count_w;
	logic         mem_we;
	logic [W-1:0] slot_w;

	assign cfg_w = W'(size_cfg_q);

	always_comb begin
		priority if (cfg_w == '0) begin
			size_eff = W'(1);
		end else if (cfg_w > DEPTH_W) begin
			size_eff = DEPTH_W;
		end else begin
			size_eff = cfg_w;
		end
	end

	// one restoring step of the remainder unit
	always_comb begin
		shifted = {rem_q, dvd_q[W-1]};
		if (shifted >= div_q) begin
			rem_next = W'(shifted - div_q);
		end else begin
			rem_next = shifted[W-1:0];
		end
	end

	assign seen_next = (seen_q == rsmp_pkg::SEEN_MAX) ? seen_q : seen_q + W'(1);
	assign count_w   = (seen_next < size_q) ? seen_next : size_q;
	assign mem_we    = (state_q == ST_APPLY) && (rem_q < size_q);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[rem_q[AW-1:0]] <= item_q;
		end
		rd_q <= mem[k_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			size_cfg_q <= rsmp_pkg::SIZE_RESET;
			seen_q     <= '0;
			item_q     <= '0;
			last_q     <= 1'b0;
			size_q     <= '0;
			rem_q      <= '0;
			dvd_q      <= '0;
			div_q      <= '0;
			k_q        <= '0;
			count_q    <= '0;
			step_q     <= '0;
		end else begin
			if (cfg_we) begin
				size_cfg_q <= cfg_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						item_q <= in_data.item_value;
						last_q <= in_data.last_item;
						size_q <= size_eff;
						dvd_q  <= in_data.random_word;
						div_q  <= {1'b0, seen_q} + (W+1)'(1);
						step_q <= '0;
						if (seen_q < size_eff) begin
							rem_q   <= seen_q;
							state_q <= ST_APPLY;
						end else begin
							rem_q   <= '0;
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					rem_q  <= rem_next;
					dvd_q  <= {dvd_q[W-2:0], 1'b0};
					step_q <= step_q + rsmp_pkg::STEP_W'(1);
					if (step_q == '1) begin
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					if (last_q) begin
						seen_q  <= '0;
						count_q <= SZ_W'(count_w);
						k_q     <= '0;
						state_q <= ST_EMIT_RD;
					end else begin
						seen_q  <= seen_next;
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_OUT;
				end
				ST_EMIT_OUT: begin
					if (!out_stall) begin
						if (k_q + SZ_W'(1) == count_q) begin
							state_q <= ST_IDLE;
						end else begin
							k_q     <= k_q + SZ_W'(1);
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign slot_w = W'(k_q);

	assign in_stall              = (state_q != ST_IDLE);
	assign out_valid             = (state_q == ST_EMIT_OUT);
	assign out_data.sample_slot  = slot_w[rsmp_pkg::SLOT_W-1:0];
	assign out_data.sample_value = rd_q;
	assign out_data.last_sample  = (k_q + SZ_W'(1) == count_q);

`ifndef SYNTHESIS
	a_no_req_while_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("request accepted while samples pending");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("block ready right after accepting a request");

	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && out_data.last_sample) |=> !out_valid)
		else $error("sample emitted after the last sample");
`endif

endmodule
